/* src/rob_pkg.sv */
package rob_pkg;

   localparam int OP_W  = 2;
   localparam int CAP_W = 5;
   localparam int OCC_W = 5;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_PUSH         = 2'd0;
   localparam op_type OP_RETIRE       = 2'd1;
   localparam op_type OP_COMPLETE     = 2'd2;
   localparam op_type OP_COMPLETE_STR = 2'd3;

endpackage

/* src/reorder_buffer_commit.sv */
// Reorder buffer, commit side. Entries live in memories with registered read data.
// Push: result in the cycle after the word; the next word is taken once the result can leave.
// Complete: walks every held entry from the head, one entry tag read and compared per cycle.
// Retire: reads the head, then one result per retired entry while the output can take it; failure when
// empty or when the head is not done. Synchronous active-high reset empties the buffer and
// sets capacity to 16; entry contents are not cleared.
module reorder_buffer_commit #(
   parameter int DEPTH      = 16,
   parameter int TAG_BITS   = 6,
   parameter int INSTR_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic                                   csr_we,
   input  logic [rob_pkg::CAP_W-1:0]              csr_wdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // op, tag, is_store, instr_num
   input  logic [((rob_pkg::OP_W+TAG_BITS+1+INSTR_BITS+7)/8)*8-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // ok, retired_valid, retired_instr, retired_tag, occupancy
   output logic [((2+INSTR_BITS+TAG_BITS+rob_pkg::OCC_W+7)/8)*8-1:0] rsp_tdata,
   output logic                                   rsp_tlast
);
   import rob_pkg::*;

   localparam int RSP_W = ((2 + INSTR_BITS + TAG_BITS + OCC_W + 7) / 8) * 8;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_COMP  = 3'd1;
   localparam logic [2:0] S_R1    = 3'd2;
   localparam logic [2:0] S_R2    = 3'd3;
   localparam logic [2:0] S_RLAST = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;

   logic [TAG_BITS-1:0]   tag_mem   [DEPTH];
   logic                  store_mem [DEPTH];
   logic [INSTR_BITS-1:0] instr_mem [DEPTH];
   logic                  done_mem  [DEPTH];

   logic [2:0]            state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CAP_W-1:0]      cap_ff;
   logic [TAG_BITS-1:0]   key_tag_ff, key_tag_in;
   logic                  key_store_ff, key_store_in;
   logic [CNT_W-1:0]      walk_ff, walk_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pend_addr_ff, pend_addr_in;
   logic [TAG_BITS-1:0]   cur_tag_ff, cur_tag_in;
   logic [INSTR_BITS-1:0] cur_instr_ff, cur_instr_in;

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [TAG_BITS-1:0]   rd_tag_ff;
   logic                  rd_store_ff;
   logic [INSTR_BITS-1:0] rd_instr_ff;
   logic                  rd_done_ff;

   logic                  push_we;
   logic [IDX_W-1:0]      push_addr;
   logic                  done_we;
   logic [IDX_W-1:0]      done_addr;
   logic                  done_val;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic                  rsp_rv_ff, rsp_rv_in;
   logic [INSTR_BITS-1:0] rsp_instr_ff, rsp_instr_in;
   logic [TAG_BITS-1:0]   rsp_tag_ff, rsp_tag_in;
   logic [OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;
   logic                  rsp_last_ff, rsp_last_in;

   op_type                req_op;
   logic [TAG_BITS-1:0]   req_tag;
   logic                  req_store;
   logic [INSTR_BITS-1:0] req_instr;
   logic                  out_free;
   logic                  accept;
   logic [CNT_W-1:0]      limit;
   logic [IDX_W-1:0]      head_next;

   function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
      logic [IDX_W:0] s;
      s = {1'b0, base} + (IDX_W + 1)'(off);
      if (s >= (IDX_W + 1)'(DEPTH)) begin
         s = s - (IDX_W + 1)'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   assign req_op    = req_tdata[OP_W-1:0];
   assign req_tag   = req_tdata[OP_W +: TAG_BITS];
   assign req_store = req_tdata[OP_W + TAG_BITS];
   assign req_instr = req_tdata[OP_W + TAG_BITS + 1 +: INSTR_BITS];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign limit      = (32'(cap_ff) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(cap_ff);
   assign head_next  = slot(head_ff, CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      key_tag_in   = key_tag_ff;
      key_store_in = key_store_ff;
      walk_in      = walk_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      cur_tag_in   = cur_tag_ff;
      cur_instr_in = cur_instr_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      push_we      = 1'b0;
      push_addr    = slot(head_ff, count_ff);
      done_we      = 1'b0;
      done_addr    = push_addr;
      done_val     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_rv_in    = rsp_rv_ff;
      rsp_instr_in = rsp_instr_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     rsp_rv_in    = 1'b0;
                     rsp_instr_in = '0;
                     rsp_tag_in   = '0;
                     rsp_last_in  = 1'b1;
                     if (count_ff < limit) begin
                        push_we     = 1'b1;
                        done_we     = 1'b1;
                        done_val    = 1'b0;
                        count_in    = count_ff + CNT_W'(1);
                        rsp_ok_in   = 1'b1;
                        rsp_occ_in  = OCC_W'(count_ff + CNT_W'(1));
                     end else begin
                        rsp_ok_in   = 1'b0;
                        rsp_occ_in  = OCC_W'(count_ff);
                     end
                  end
                  OP_RETIRE: begin
                     if (count_ff == '0) begin
                        state_in = S_FIN;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = S_R1;
                     end
                  end
                  default: begin
                     key_tag_in   = req_tag;
                     key_store_in = (req_op == OP_COMPLETE_STR);
                     walk_in      = '0;
                     state_in     = S_COMP;
                  end
               endcase
            end
         end
         S_COMP: begin
            if (walk_ff < count_ff) begin
               rd_en        = 1'b1;
               rd_addr      = slot(head_ff, walk_ff);
               walk_in      = walk_ff + CNT_W'(1);
               pend_in      = 1'b1;
               pend_addr_in = rd_addr;
            end else if (!pend_ff) begin
               state_in = S_FIN;
            end
            if (pend_ff && rd_tag_ff == key_tag_ff && rd_store_ff == key_store_ff) begin
               done_we   = 1'b1;
               done_addr = pend_addr_ff;
               done_val  = 1'b1;
            end
         end
         S_R1: begin
            if (!rd_done_ff) begin
               state_in = S_FIN;
            end else begin
               cur_tag_in   = rd_tag_ff;
               cur_instr_in = rd_instr_ff;
               head_in      = head_next;
               count_in     = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = S_RLAST;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = head_next;
                  state_in = S_R2;
               end
            end
         end
         S_R2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_rv_in    = 1'b1;
               rsp_instr_in = cur_instr_ff;
               rsp_tag_in   = cur_tag_ff;
               rsp_occ_in   = OCC_W'(count_ff);
               rsp_last_in  = !rd_done_ff;
               if (rd_done_ff) begin
                  cur_tag_in   = rd_tag_ff;
                  cur_instr_in = rd_instr_ff;
                  head_in      = head_next;
                  count_in     = count_ff - CNT_W'(1);
                  if (count_ff == CNT_W'(1)) begin
                     state_in = S_RLAST;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = head_next;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RLAST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_rv_in    = 1'b1;
               rsp_instr_in = cur_instr_ff;
               rsp_tag_in   = cur_tag_ff;
               rsp_occ_in   = OCC_W'(count_ff);
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_rv_in    = 1'b0;
               rsp_instr_in = '0;
               rsp_tag_in   = '0;
               rsp_occ_in   = OCC_W'(count_ff);
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_we) begin
         tag_mem[push_addr]   <= req_tag;
         store_mem[push_addr] <= req_store;
         instr_mem[push_addr] <= req_instr;
      end
      if (done_we) begin
         done_mem[done_addr] <= done_val;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff   <= tag_mem[rd_addr];
         rd_store_ff <= store_mem[rd_addr];
         rd_instr_ff <= instr_mem[rd_addr];
         rd_done_ff  <= done_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_W'(16);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_tag_ff   <= key_tag_in;
      key_store_ff <= key_store_in;
      walk_ff      <= walk_in;
      pend_addr_ff <= pend_addr_in;
      cur_tag_ff   <= cur_tag_in;
      cur_instr_ff <= cur_instr_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_rv_ff    <= rsp_rv_in;
      rsp_instr_ff <= rsp_instr_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_W'({rsp_occ_ff, rsp_tag_ff, rsp_instr_ff, rsp_rv_ff, rsp_ok_ff});

endmodule
